// ----- src/isl_pkg.sv -----
// shared types, constants and codes of the indexed shifting list
package isl_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;
   localparam int STEP_W   = $clog2(IDX_W);

   // field widths
   localparam int ACT_W     = 2;
   localparam int TAG_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int STAT_W    = 2;

   // stream data widths, padded to whole bytes
   localparam int REQ_BITS = ACT_W + CNT_W + CNT_W + TAG_W + PAYLOAD_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = TAG_W + PAYLOAD_W + CNT_W + STAT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // action codes
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ARG_BAD   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OUT_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_READ   = 2'd2;
   localparam logic [1:0] CELL_SHIFT  = 2'd3;

   // one stored element
   typedef struct packed {
      logic [TAG_W-1:0]     tag;
      logic [PAYLOAD_W-1:0] payload;
   } slot_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic [1:0]        op;
      logic [CNT_W-1:0]  pos;
      logic [STEP_W-1:0] step;
      slot_type          new_slot;
   } cell_cmd_type;

endpackage

// ----- src/isl_cell.sv -----
// one slot of the list chain: holds an element and moves it on insert and shift commands
module isl_cell import isl_pkg::*; (
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  logic [IDX_W-1:0]        cell_idx,
   input  slot_type                below_slot,
   input  slot_type [IDX_W-1:0]    up_slot,
   output slot_type                slot_q,
   output slot_type                read_q
);

   slot_type         slot_ff, slot_in;
   slot_type         read_ff, read_in;
   logic [CNT_W-1:0] idx_ext;

   assign idx_ext = {1'b0, cell_idx};

   // slot update: open a gap on insert, pull from above on a gap-closing shift
   always_comb begin
      slot_in = slot_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (idx_ext > cmd.pos) begin
               slot_in = below_slot;
            end else if (idx_ext == cmd.pos) begin
               slot_in = cmd.new_slot;
            end
         end
         CELL_SHIFT: begin
            if (idx_ext >= cmd.pos) begin
               slot_in = up_slot[cmd.step];
            end
         end
         default: slot_in = slot_ff;
      endcase
   end

   // read tap: only the addressed cell drives nonzero data
   always_comb begin
      read_in = read_ff;
      if (cmd.op == CELL_READ) begin
         read_in = (idx_ext == cmd.pos) ? slot_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      read_ff <= read_in;
   end

   assign slot_q = slot_ff;
   assign read_q = read_ff;

endmodule

// ----- src/isl_ctrl.sv -----
// action sequencer, size counter and result register of the list
module isl_ctrl import isl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output cell_cmd_type       cell_cmd,
   input  slot_type           read_slot
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IDX_W - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

   logic [1:0]             state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic                   get_ok_ff, get_ok_in;

   // latched item fields
   logic [ACT_W-1:0]       act_ff;
   logic [CNT_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       run_ff;
   slot_type               new_ff;

   logic                   accept;
   logic                   rsp_free;
   logic [CNT_W:0]         run_end;
   slot_type               out_slot;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && rsp_free);
   assign accept     = req_tvalid && req_tready;
   assign run_end    = {1'b0, pos_ff} + {1'b0, run_ff};

   // sequencer
   always_comb begin
      state_in           = state_ff;
      step_in            = step_ff;
      count_in           = count_ff;
      status_in          = status_ff;
      get_ok_in          = get_ok_ff;
      cell_cmd.op        = CELL_HOLD;
      cell_cmd.pos       = pos_ff;
      cell_cmd.step      = step_ff;
      cell_cmd.new_slot  = new_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = STAT_OK;
            get_ok_in = 1'b0;
            step_in   = '0;
            state_in  = S_DONE;
            unique case (act_ff)
               ACT_INSERT: begin
                  if (pos_ff > count_ff) begin
                     status_in = STAT_ARG_BAD;
                  end else if (new_ff.tag == '0) begin
                     status_in = STAT_OK;
                  end else if (count_ff >= FULL_CNT) begin
                     status_in = STAT_FULL;
                  end else begin
                     cell_cmd.op = CELL_INSERT;
                     count_in    = count_ff + 1'b1;
                  end
               end
               ACT_GET: begin
                  if (pos_ff >= count_ff) begin
                     status_in = STAT_OUT_RANGE;
                  end else begin
                     cell_cmd.op = CELL_READ;
                     get_ok_in   = 1'b1;
                  end
               end
               ACT_REMOVE: begin
                  if (run_end > {1'b0, count_ff}) begin
                     status_in = STAT_ARG_BAD;
                  end else begin
                     count_in = count_ff - run_ff;
                     if (run_ff[IDX_W-1:0] != '0) begin
                        state_in = S_SHIFT;
                     end
                  end
               end
               ACT_CLEAR: begin
                  count_in = '0;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SHIFT: begin
            // close the gap by one power-of-two distance per step
            if (run_ff[step_ff]) begin
               cell_cmd.op = CELL_SHIFT;
            end
            if (step_ff == LAST_STEP) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = accept ? S_EXEC : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      out_slot     = get_ok_ff ? read_slot : '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({status_ff, count_ff, out_slot.payload, out_slot.tag});
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      status_ff   <= status_in;
      get_ok_ff   <= get_ok_in;
      if (accept) begin
         act_ff          <= req_tdata[ACT_W-1:0];
         pos_ff          <= req_tdata[ACT_W +: CNT_W];
         run_ff          <= req_tdata[ACT_W+CNT_W +: CNT_W];
         new_ff.tag      <= req_tdata[ACT_W+2*CNT_W +: TAG_W];
         new_ff.payload  <= req_tdata[ACT_W+2*CNT_W+TAG_W +: PAYLOAD_W];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- src/indexed_shifting_list.sv -----
// top level of the indexed shifting list: cell chain, read gather and sequencer
//
// Ordered list of up to 64 tagged 64-bit values kept in a chain of slot cells.
// Each item carries one action: insert, get, remove run or clear, and gives
// exactly one result with the read value, the new list size and a status.
// Insert, get, clear and every rejected action pass an execute state, where
// the whole chain shifts, writes or taps the addressed slot, and a done
// state that gathers the tapped slot into the result register. A valid
// remove of a run of 1 to 63 slots passes a shift state in between, in
// which the chain closes the gap in six fixed steps of distance 1, 2, 4,
// 8, 16 and 32 slots; a remove of no slots or of all 64 moves nothing. The
// result register lets the next item be taken while a result still waits; a
// result that is still held when the next one is ready stalls the input. Slot
// contents need no initialization after reset; only the size is cleared.
module indexed_shifting_list import isl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // action, position, run_length, item_tag, item_payload (low bit first)
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   // read_tag, read_payload, list_size, status (low bit first)
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata
);

   cell_cmd_type cell_cmd;
   slot_type     cell_slot [CAPACITY];
   slot_type     cell_read [CAPACITY];
   slot_type     read_slot;

   // chain of slot cells with their fixed neighbor taps
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slot_type             below_slot;
      slot_type [IDX_W-1:0] up_slot;

      if (i == 0) begin : g_first
         assign below_slot = '0;
      end else begin : g_rest
         assign below_slot = cell_slot[i-1];
      end

      for (genvar k = 0; k < IDX_W; k++) begin : g_up
         if (i + (1 << k) < CAPACITY) begin : g_tap
            assign up_slot[k] = cell_slot[i + (1 << k)];
         end else begin : g_end
            assign up_slot[k] = '0;
         end
      end

      isl_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .cell_idx   (IDX_W'(i)),
         .below_slot (below_slot),
         .up_slot    (up_slot),
         .slot_q     (cell_slot[i]),
         .read_q     (cell_read[i])
      );
   end

   // gather the tapped slot; all other taps are zero
   always_comb begin
      read_slot = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_slot = read_slot | cell_read[i];
      end
   end

   isl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cell_cmd   (cell_cmd),
      .read_slot  (read_slot)
   );

endmodule

// ----- src/isl_checker.sv -----
// port-level checks on the indexed shifting list results
module isl_checker import isl_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [TAG_W-1:0]     rsp_tag;
   logic [PAYLOAD_W-1:0] rsp_payload;
   logic [CNT_W-1:0]     rsp_size;
   logic [STAT_W-1:0]    rsp_status;
   logic                 req_seen;

   assign rsp_tag     = rsp_tdata[TAG_W-1:0];
   assign rsp_payload = rsp_tdata[TAG_W +: PAYLOAD_W];
   assign rsp_size    = rsp_tdata[TAG_W+PAYLOAD_W +: CNT_W];
   assign rsp_status  = rsp_tdata[TAG_W+PAYLOAD_W+CNT_W +: STAT_W];
   assign req_seen    = req_tvalid && req_tready;

   // a failed action never returns read data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != STAT_OK) |-> (rsp_tag == '0) && (rsp_payload == '0))
      else $error("failed action returned read data");

   // size never exceeds the capacity
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_size <= CNT_W'(CAPACITY))
      else $error("list size beyond capacity");

   // capacity exhausted only reported with a full list
   a_full_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == STAT_FULL) |-> rsp_size == CNT_W'(CAPACITY))
      else $error("full status with list not full");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // no result appears in the cycle right after reset without an item taken
   a_no_early_rsp: assert property (@(posedge clock)
      $fell(reset) && !req_seen |-> !rsp_tvalid)
      else $error("result without an item");

endmodule

bind indexed_shifting_list isl_checker u_isl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/indexed_shifting_list_tb.sv -----
// testbench of the indexed shifting list: directed table, random actions, mirrored list model
module indexed_shifting_list_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import isl_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 350;

   // one action as packed on req_tdata, first field lowest
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [TAG_W-1:0]     tag;
      logic [CNT_W-1:0]     run;
      logic [CNT_W-1:0]     pos;
      logic [ACT_W-1:0]     act;
   } list_action_type;

   // one result as packed on rsp_tdata, first field lowest
   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic [CNT_W-1:0]     size;
      logic [PAYLOAD_W-1:0] payload;
      logic [TAG_W-1:0]     tag;
   } list_result_type;

   // directed row: action, then the typed result where fixed is set
   typedef struct packed {
      logic                 fixed;
      logic [ACT_W-1:0]     act;
      logic [CNT_W-1:0]     pos;
      logic [CNT_W-1:0]     run;
      logic [TAG_W-1:0]     tag;
      logic [PAYLOAD_W-1:0] payload;
      logic [STAT_W-1:0]    status;
      logic [CNT_W-1:0]     size;
      logic [TAG_W-1:0]     rtag;
      logic [PAYLOAD_W-1:0] rpayload;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // mirrored list contents and size
   logic [TAG_W-1:0]     mirror_tag [CAPACITY];
   logic [PAYLOAD_W-1:0] mirror_payload [CAPACITY];
   int                   mirror_size = 0;

   list_result_type  awaited_results [$];
   directed_row_type directed_rows [23];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   bit               hold_rsp_request = 1'b0;

   indexed_shifting_list uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // apply one action to the mirrored list and return its result
   function automatic list_result_type apply_list_action(input list_action_type a);
      list_result_type res;
      int p;
      int r;
      int i;
      res = '0;
      res.status = STAT_OK;
      p = a.pos;
      r = a.run;
      case (a.act)
         ACT_INSERT: begin
            if (p > mirror_size) begin
               res.status = STAT_ARG_BAD;
            end else if (a.tag == '0) begin
               res.status = STAT_OK;
            end else if (mirror_size >= CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               for (i = mirror_size; i > p; i--) begin
                  mirror_tag[i]     = mirror_tag[i-1];
                  mirror_payload[i] = mirror_payload[i-1];
               end
               mirror_tag[p]     = a.tag;
               mirror_payload[p] = a.payload;
               mirror_size++;
            end
         end
         ACT_GET: begin
            if (p >= mirror_size) begin
               res.status = STAT_OUT_RANGE;
            end else begin
               res.tag     = mirror_tag[p];
               res.payload = mirror_payload[p];
            end
         end
         ACT_REMOVE: begin
            if (p + r > mirror_size) begin
               res.status = STAT_ARG_BAD;
            end else begin
               for (i = p; i + r < mirror_size; i++) begin
                  mirror_tag[i]     = mirror_tag[i+r];
                  mirror_payload[i] = mirror_payload[i+r];
               end
               mirror_size -= r;
            end
         end
         default: begin
            mirror_size = 0;
         end
      endcase
      res.size = CNT_W'(mirror_size);
      return res;
   endfunction

   function automatic list_action_type make_action(input logic [ACT_W-1:0] act, input int pos,
         input int run, input int tag, input logic [PAYLOAD_W-1:0] payload);
      list_action_type a;
      a.act     = act;
      a.pos     = CNT_W'(pos);
      a.run     = CNT_W'(run);
      a.tag     = TAG_W'(tag);
      a.payload = payload;
      return a;
   endfunction

   // random action, mostly well formed for the current size, some noise
   function automatic list_action_type random_list_action(input int ins_weight);
      list_action_type a;
      int pick;
      int room;
      bit noise;
      a.payload = {$urandom, $urandom};
      a.tag     = TAG_W'($urandom_range(0, 15));
      a.pos     = CNT_W'($urandom_range(0, CAPACITY));
      a.run     = CNT_W'($urandom_range(0, CAPACITY));
      pick  = $urandom_range(0, 99);
      noise = ($urandom_range(0, 9) == 0);
      if (pick < ins_weight) begin
         a.act = ACT_INSERT;
         if (!noise) a.pos = CNT_W'($urandom_range(0, mirror_size));
      end else if (pick < ins_weight + 30) begin
         a.act = ACT_GET;
         if (!noise && mirror_size > 0) a.pos = CNT_W'($urandom_range(0, mirror_size - 1));
      end else if (pick < 96) begin
         a.act = ACT_REMOVE;
         if (!noise) begin
            a.pos = CNT_W'($urandom_range(0, mirror_size));
            room  = mirror_size - int'(a.pos);
            if ($urandom_range(0, 3) == 0 || room < 4) begin
               a.run = CNT_W'($urandom_range(0, room));
            end else begin
               a.run = CNT_W'($urandom_range(0, 4));
            end
         end
      end else begin
         a.act = ACT_CLEAR;
      end
      return a;
   endfunction

   // offer one item, predict at acceptance, then idle between bursts
   task automatic offer_item(input list_action_type a, input logic fixed,
         input list_result_type typed_res);
      list_result_type predicted;
      logic [REQ_W-1:0] word;
      int gap;
      word = '0;
      word[REQ_BITS-1:0] = a;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_action(a);
      awaited_results.push_back(fixed ? typed_res : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 7);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering until every awaited result is in, then let the block settle
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      list_action_type a;
      list_result_type want;
      int n;
      directed_rows = '{
         '{1'b1, ACT_GET,    7'd0,  7'd0,  4'd0,  64'd0, STAT_OUT_RANGE, 7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_REMOVE, 7'd0,  7'd0,  4'd0,  64'd0, STAT_OK,        7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_REMOVE, 7'd0,  7'd1,  4'd0,  64'd0, STAT_ARG_BAD,   7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_INSERT, 7'd1,  7'd0,  4'd5,  64'd7, STAT_ARG_BAD,   7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_INSERT, 7'd0,  7'd0,  4'd0,  '1,    STAT_OK,        7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_INSERT, 7'd0,  7'd0,  4'd15, '1,    STAT_OK,        7'd1, 4'd0, 64'd0},
         '{1'b1, ACT_GET,    7'd0,  7'd0,  4'd0,  64'd0, STAT_OK,        7'd1, 4'd15, '1},
         '{1'b1, ACT_GET,    7'd1,  7'd0,  4'd0,  64'd0, STAT_OUT_RANGE, 7'd1, 4'd0, 64'd0},
         '{1'b1, ACT_INSERT, 7'd1,  7'd0,  4'd1,  64'd0, STAT_OK,        7'd2, 4'd0, 64'd0},
         '{1'b1, ACT_INSERT, 7'd0,  7'd0,  4'd8,  64'h0123_4567_89ab_cdef,
           STAT_OK, 7'd3, 4'd0, 64'd0},
         '{1'b0, ACT_GET,    7'd1,  7'd0,  4'd0,  64'd0, STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b0, ACT_GET,    7'd2,  7'd0,  4'd0,  64'd0, STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b0, ACT_INSERT, 7'd2,  7'd0,  4'd10, 64'h8000_0000_0000_0001,
           STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b0, ACT_REMOVE, 7'd1,  7'd2,  4'd0,  64'd0, STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b0, ACT_GET,    7'd1,  7'd0,  4'd0,  64'd0, STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_REMOVE, 7'd64, 7'd64, 4'd0,  64'd0, STAT_ARG_BAD,   7'd2, 4'd0, 64'd0},
         '{1'b1, ACT_GET,    7'd64, 7'd0,  4'd0,  64'd0, STAT_OUT_RANGE, 7'd2, 4'd0, 64'd0},
         '{1'b1, ACT_INSERT, 7'd64, 7'd0,  4'd3,  64'd0, STAT_ARG_BAD,   7'd2, 4'd0, 64'd0},
         '{1'b0, ACT_REMOVE, 7'd2,  7'd0,  4'd0,  64'd0, STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b0, ACT_REMOVE, 7'd0,  7'd2,  4'd0,  64'd0, STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b0, ACT_INSERT, 7'd0,  7'd0,  4'd7,  64'h5a5a_a5a5_5a5a_a5a5,
           STAT_OK, 7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_CLEAR,  7'd0,  7'd0,  4'd0,  64'd0, STAT_OK,        7'd0, 4'd0, 64'd0},
         '{1'b1, ACT_GET,    7'd0,  7'd0,  4'd0,  64'd0, STAT_OUT_RANGE, 7'd0, 4'd0, 64'd0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[k]) begin
         a = make_action(directed_rows[k].act, directed_rows[k].pos, directed_rows[k].run,
                         directed_rows[k].tag, directed_rows[k].payload);
         want.status  = directed_rows[k].status;
         want.size    = directed_rows[k].size;
         want.tag     = directed_rows[k].rtag;
         want.payload = directed_rows[k].rpayload;
         offer_item(a, directed_rows[k].fixed, want);
      end
      wait_for_drain();

      // fill the list to capacity, long receiver hold halfway
      while (mirror_size < CAPACITY) begin
         if (mirror_size == CAPACITY / 2) hold_rsp_request = 1'b1;
         offer_item(make_action(ACT_INSERT, $urandom_range(0, mirror_size), 0,
                                $urandom_range(1, 15), {$urandom, $urandom}), 1'b0, '0);
         if ($urandom_range(0, 4) == 0) begin
            offer_item(make_action(ACT_GET, $urandom_range(0, mirror_size - 1), 0, 0, '0),
                       1'b0, '0);
         end
      end

      // full list cases
      offer_item(make_action(ACT_INSERT, 64, 0, 9, '1), 1'b1, '{STAT_FULL, 7'd64, 64'd0, 4'd0});
      offer_item(make_action(ACT_INSERT, 10, 0, 2, '0), 1'b1, '{STAT_FULL, 7'd64, 64'd0, 4'd0});
      offer_item(make_action(ACT_INSERT, 5, 0, 0, '1), 1'b1, '{STAT_OK, 7'd64, 64'd0, 4'd0});
      offer_item(make_action(ACT_GET, 63, 0, 0, '0), 1'b0, '0);
      offer_item(make_action(ACT_GET, 64, 0, 0, '0), 1'b1, '{STAT_OUT_RANGE, 7'd64, 64'd0, 4'd0});
      offer_item(make_action(ACT_REMOVE, 64, 0, 0, '0), 1'b1, '{STAT_OK, 7'd64, 64'd0, 4'd0});
      offer_item(make_action(ACT_REMOVE, 1, 64, 0, '0), 1'b1, '{STAT_ARG_BAD, 7'd64, 64'd0, 4'd0});
      wait_for_drain();
      offer_item(make_action(ACT_REMOVE, 0, 64, 0, '0), 1'b1, '{STAT_OK, 7'd0, 64'd0, 4'd0});

      // random actions in insert-heavy and balanced stretches
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) hold_rsp_request = 1'b1;
         if (n == 300) wait_for_drain();
         a = random_list_action(((n / 75) % 2 == 1) ? 60 : 35);
         offer_item(a, 1'b0, '0);
      end

      wait_for_drain();
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // receiver stall pattern, with a long hold on request
   initial begin : receiver
      int mode;
      int mode_left;
      int tick;
      mode = 0;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= (tick % 3 == 0);
         endcase
      end
   end

   // check each accepted result against the oldest awaited one
   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_BITS-1:0];
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: tag %h payload %h size %0d status %0d",
                        got.tag, got.payload, got.size, got.status);
            end
         end else begin
            want = awaited_results.pop_front();
            if (got.tag !== want.tag || got.payload !== want.payload ||
                  got.size !== want.size || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected tag %h payload %h size %0d status %0d",
                           want.tag, want.payload, want.size, want.status);
                  $display("          actual   tag %h payload %h size %0d status %0d",
                           got.tag, got.payload, got.size, got.status);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
